@@ design/mcp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared constants and types for the motor command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mcp_pkg;

    localparam int MAX_NAME_CHARS = 8;

    localparam logic [7:0] CH_START  = 8'h7E;
    localparam logic [7:0] CH_END    = 8'h2A;
    localparam logic [7:0] CH_RENAME = 8'h5E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] FLD_MOTOR     = 2'd0;
    localparam logic [1:0] FLD_PWM       = 2'd1;
    localparam logic [1:0] FLD_DIRECTION = 2'd2;
    localparam logic [1:0] FLD_RATE      = 2'd3;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_NAME_MISMATCH = 3'd1;
    localparam logic [2:0] ST_BAD_MOTOR     = 3'd2;
    localparam logic [2:0] ST_FIELD_LONG    = 3'd6;
    localparam logic [2:0] ST_RENAME        = 3'd7;

    localparam logic [1:0] DIR_NO_CHANGE  = 2'd2;
    localparam logic [2:0] RATE_NO_CHANGE = 3'd4;

    localparam logic       CFG_NODE_NAME   = 1'b0;
    localparam logic       CFG_NAME_LENGTH = 1'b1;

    typedef struct packed {
        logic       ok;
        logic [2:0] value;
    } code_dec_t;

endpackage

`default_nettype wire

@@ design/motor_command_parser.sv @@
// ----------------------------------------------------------------------------
// motor_command_parser
// Byte-serial parser for '~name*mm*pp*dd*rr*' motor command messages.
// ----------------------------------------------------------------------------
// Each received byte is held in the input register, then passes the parse logic
// into the result register; one byte is accepted per cycle unless stalled. The
// only stall is a held result word that the sink has not taken. Write node_name
// and name_length through the cfg port while no message is in flight.
`default_nettype none

module motor_command_parser #(
    parameter int MAX_NAME_CHARS = mcp_pkg::MAX_NAME_CHARS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // status[2:0], motor_mode[4:3], pwm_channel[6:5],
                                        // direction[8:7], rate_code[11:9], zero[15:12]
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_NAME,
        PH_F0,
        PH_F1,
        PH_F2
    } phase_t;

    localparam logic [3:0] NAME_CAP = 4'(MAX_NAME_CHARS);

    logic [63:0] node_name_reg;
    logic [3:0]  name_length_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  name_pos_reg, name_pos_next;
    logic [15:0] field_chars_reg, field_chars_next;
    logic [1:0]  field_count_reg, field_count_next;
    logic [1:0]  held_motor_reg, held_motor_next;
    logic [1:0]  held_pwm_reg, held_pwm_next;
    logic [1:0]  held_direction_reg, held_direction_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [1:0]  motor_reg, motor_next;
    logic [1:0]  pwm_reg, pwm_next;
    logic [1:0]  direction_reg, direction_next;
    logic [2:0]  rate_reg, rate_next;

    logic               proc_fire;
    logic               emit;
    logic [3:0]         len;
    logic [7:0]         name_char;
    mcp_pkg::code_dec_t dec;

    mcp_code_decode u_decode (
        .field_sel (field_count_reg),
        .chars     (field_chars_reg),
        .dec       (dec)
    );

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, rate_reg, direction_reg, pwm_reg, motor_reg, status_reg};

    assign len       = (name_length_reg > NAME_CAP) ? NAME_CAP : name_length_reg;
    assign name_char = node_name_reg[{name_pos_reg[2:0], 3'b000} +: 8];

    always_comb begin
        phase_next          = phase_reg;
        name_pos_next       = name_pos_reg;
        field_chars_next    = field_chars_reg;
        field_count_next    = field_count_reg;
        held_motor_next     = held_motor_reg;
        held_pwm_next       = held_pwm_reg;
        held_direction_next = held_direction_reg;
        emit                = 1'b0;
        status_next         = mcp_pkg::ST_OK;
        motor_next          = 2'd0;
        pwm_next            = 2'd0;
        direction_next      = 2'd0;
        rate_next           = 3'd0;

        if (in_byte_reg == mcp_pkg::CH_START) begin
            phase_next       = PH_NAME;
            name_pos_next    = 4'd0;
            field_chars_next = 16'd0;
            field_count_next = 2'd0;
        end else begin
            unique case (phase_reg)
                PH_NAME: begin
                    if (in_byte_reg == mcp_pkg::CH_END) begin
                        if (name_pos_reg != len) begin
                            emit        = 1'b1;
                            status_next = mcp_pkg::ST_NAME_MISMATCH;
                            phase_next  = PH_HUNT;
                        end else begin
                            phase_next       = PH_F0;
                            field_chars_next = 16'd0;
                            field_count_next = 2'd0;
                        end
                    end else if (name_pos_reg >= len || in_byte_reg != name_char) begin
                        emit        = 1'b1;
                        status_next = mcp_pkg::ST_NAME_MISMATCH;
                        phase_next  = PH_HUNT;
                    end else begin
                        name_pos_next = name_pos_reg + 4'd1;
                    end
                end
                PH_F0, PH_F1, PH_F2: begin
                    if (in_byte_reg != mcp_pkg::CH_END) begin
                        if (phase_reg == PH_F0 && field_count_reg == 2'd0
                                && in_byte_reg == mcp_pkg::CH_RENAME) begin
                            emit        = 1'b1;
                            status_next = mcp_pkg::ST_RENAME;
                            phase_next  = PH_HUNT;
                        end else if (phase_reg == PH_F2) begin
                            emit        = 1'b1;
                            status_next = mcp_pkg::ST_FIELD_LONG;
                            phase_next  = PH_HUNT;
                        end else begin
                            field_chars_next = {field_chars_reg[7:0], in_byte_reg};
                            phase_next       = (phase_reg == PH_F0) ? PH_F1 : PH_F2;
                        end
                    end else if (phase_reg != PH_F2 || !dec.ok) begin
                        emit        = 1'b1;
                        status_next = mcp_pkg::ST_BAD_MOTOR + {1'b0, field_count_reg};
                        phase_next  = PH_HUNT;
                    end else if (field_count_reg == mcp_pkg::FLD_RATE) begin
                        emit           = 1'b1;
                        motor_next     = held_motor_reg;
                        pwm_next       = held_pwm_reg;
                        direction_next = held_direction_reg;
                        rate_next      = dec.value;
                        phase_next     = PH_HUNT;
                    end else begin
                        case (field_count_reg)
                            mcp_pkg::FLD_MOTOR: held_motor_next     = dec.value[1:0];
                            mcp_pkg::FLD_PWM:   held_pwm_next       = dec.value[1:0];
                            default:            held_direction_next = dec.value[1:0];
                        endcase
                        field_count_next = field_count_reg + 2'd1;
                        field_chars_next = 16'd0;
                        phase_next       = PH_F0;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (proc_fire && emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_name_reg      <= 64'd297632810306;
            name_length_reg    <= 4'd5;
            in_valid_reg       <= 1'b0;
            phase_reg          <= PH_HUNT;
            name_pos_reg       <= 4'd0;
            field_chars_reg    <= 16'd0;
            field_count_reg    <= 2'd0;
            held_motor_reg     <= 2'd0;
            held_pwm_reg       <= 2'd0;
            held_direction_reg <= 2'd0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mcp_pkg::CFG_NODE_NAME:   node_name_reg   <= cfg_wr_data;
                    mcp_pkg::CFG_NAME_LENGTH: name_length_reg <= cfg_wr_data[3:0];
                    default: ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_fire) begin
                phase_reg          <= phase_next;
                name_pos_reg       <= name_pos_next;
                field_chars_reg    <= field_chars_next;
                field_count_reg    <= field_count_next;
                held_motor_reg     <= held_motor_next;
                held_pwm_reg       <= held_pwm_next;
                held_direction_reg <= held_direction_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (proc_fire && emit) begin
            status_reg    <= status_next;
            motor_reg     <= motor_next;
            pwm_reg       <= pwm_next;
            direction_reg <= direction_next;
            rate_reg      <= rate_next;
        end
    end

`ifndef SYNTHESIS
    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_reg != mcp_pkg::ST_OK |->
            motor_reg == 2'd0 && pwm_reg == 2'd0 && direction_reg == 2'd0 && rate_reg == 3'd0)
        else $error("error result carries nonzero fields");

    a_ok_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_reg == mcp_pkg::ST_OK |->
            direction_reg <= mcp_pkg::DIR_NO_CHANGE && rate_reg <= mcp_pkg::RATE_NO_CHANGE)
        else $error("ok result out of range");

    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_byte_reg == mcp_pkg::CH_START |=>
            phase_reg == PH_NAME && name_pos_reg == 4'd0)
        else $error("start byte did not restart message");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

@@ design/mcp_code_decode.sv @@
// ----------------------------------------------------------------------------
// mcp_code_decode
// Decodes one two-character field code for the selected field.
// ----------------------------------------------------------------------------
`default_nettype none

module mcp_code_decode (
    input  wire logic [1:0]         field_sel,
    input  wire logic [15:0]        chars,
    output mcp_pkg::code_dec_t      dec
);

    logic [7:0] hi;
    logic [7:0] lo;
    logic       lo_one_to_four;

    assign hi = chars[15:8];
    assign lo = chars[7:0];
    assign lo_one_to_four = (lo >= mcp_pkg::CH_ONE) && (lo <= mcp_pkg::CH_FOUR);

    always_comb begin
        dec = '{ok: 1'b0, value: 3'd0};
        unique case (field_sel)
            mcp_pkg::FLD_MOTOR: begin
                if (hi == mcp_pkg::CH_ZERO && lo >= mcp_pkg::CH_ZERO
                        && lo <= mcp_pkg::CH_THREE) begin
                    dec.ok    = 1'b1;
                    dec.value = {1'b0, lo[1:0]};
                end
            end
            mcp_pkg::FLD_PWM: begin
                if (hi == mcp_pkg::CH_ONE && lo_one_to_four) begin
                    dec.ok    = 1'b1;
                    dec.value = 3'(lo - mcp_pkg::CH_ONE);
                end
            end
            mcp_pkg::FLD_DIRECTION: begin
                if (hi == mcp_pkg::CH_NINE && lo == mcp_pkg::CH_NINE) begin
                    dec.ok    = 1'b1;
                    dec.value = {1'b0, mcp_pkg::DIR_NO_CHANGE};
                end else if (hi == mcp_pkg::CH_TWO
                        && (lo == mcp_pkg::CH_ZERO || lo == mcp_pkg::CH_ONE)) begin
                    dec.ok    = 1'b1;
                    dec.value = {2'b00, lo[0]};
                end
            end
            default: begin
                if (hi == mcp_pkg::CH_NINE && lo == mcp_pkg::CH_NINE) begin
                    dec.ok    = 1'b1;
                    dec.value = mcp_pkg::RATE_NO_CHANGE;
                end else if (hi == mcp_pkg::CH_FOUR && lo_one_to_four) begin
                    dec.ok    = 1'b1;
                    dec.value = 3'(lo - mcp_pkg::CH_ONE);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks motor_command_parser by streaming command bytes into it. Every
// accepted byte is run through a local parser model. Each result word is
// compared with the oldest predicted report. Directed messages cover every
// motor, pwm and direction code, each name and field error, rename, restart
// and noise. Random messages follow, mostly well formed with random content
// and some corrupted, under three idle patterns and several node name settings.
// ----------------------------------------------------------------------------

module testbench;

    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        PARSE_HUNT,
        PARSE_ID,
        PARSE_FIELD_EMPTY,
        PARSE_FIELD_ONE,
        PARSE_FIELD_TWO
    } parse_phase_t;

    typedef struct packed {
        logic [3:0] pad;
        logic [2:0] rate_code;
        logic [1:0] direction;
        logic [1:0] pwm_channel;
        logic [1:0] motor_mode;
        logic [2:0] status;
    } report_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_addr    = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;

    logic [63:0]  cur_node_name   = 64'd297632810306;
    logic [3:0]   cur_name_length = 4'd5;
    parse_phase_t parse_phase     = PARSE_HUNT;
    logic [3:0]   name_index      = '0;
    logic [15:0]  code_chars      = '0;
    logic [1:0]   field_index     = '0;
    logic [1:0]   kept_motor      = '0;
    logic [1:0]   kept_pwm        = '0;
    logic [1:0]   kept_direction  = '0;

    report_t     expected_reports[$];
    logic [7:0]  frame_bytes[$];
    int unsigned bytes_sent    = 0;
    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    motor_command_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // rx_byte[7:0]
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)       // status[2:0], motor_mode[4:3], pwm_channel[6:5],
                                     // direction[8:7], rate_code[11:9], zero[15:12]
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("** motor_command_parser: FAILED **");
        $finish;
    end

    function automatic int name_chars();
        return (cur_name_length > mcp_pkg::MAX_NAME_CHARS) ? mcp_pkg::MAX_NAME_CHARS
                                                           : int'(cur_name_length);
    endfunction

    function automatic mcp_pkg::code_dec_t decode_code(input logic [1:0] field,
                                                       input logic [15:0] chars);
        logic [7:0]         hi;
        logic [7:0]         lo;
        mcp_pkg::code_dec_t d;
        hi = chars[15:8];
        lo = chars[7:0];
        d  = '{1'b0, 3'd0};
        if (hi == mcp_pkg::CH_NINE && lo == mcp_pkg::CH_NINE
                && field == mcp_pkg::FLD_DIRECTION) begin
            d = '{1'b1, 3'(mcp_pkg::DIR_NO_CHANGE)};
        end else if (hi == mcp_pkg::CH_NINE && lo == mcp_pkg::CH_NINE
                && field == mcp_pkg::FLD_RATE) begin
            d = '{1'b1, mcp_pkg::RATE_NO_CHANGE};
        end else begin
            case (field)
                mcp_pkg::FLD_MOTOR: begin
                    if (hi == mcp_pkg::CH_ZERO && lo >= mcp_pkg::CH_ZERO
                            && lo <= mcp_pkg::CH_THREE)
                        d = '{1'b1, 3'(lo - mcp_pkg::CH_ZERO)};
                end
                mcp_pkg::FLD_PWM: begin
                    if (hi == mcp_pkg::CH_ONE && lo >= mcp_pkg::CH_ONE
                            && lo <= mcp_pkg::CH_FOUR)
                        d = '{1'b1, 3'(lo - mcp_pkg::CH_ONE)};
                end
                mcp_pkg::FLD_DIRECTION: begin
                    if (hi == mcp_pkg::CH_TWO
                            && (lo == mcp_pkg::CH_ZERO || lo == mcp_pkg::CH_ONE))
                        d = '{1'b1, 3'(lo - mcp_pkg::CH_ZERO)};
                end
                default: begin
                    if (hi == mcp_pkg::CH_FOUR && lo >= mcp_pkg::CH_ONE
                            && lo <= mcp_pkg::CH_FOUR)
                        d = '{1'b1, 3'(lo - mcp_pkg::CH_ONE)};
                end
            endcase
        end
        return d;
    endfunction

    function automatic void reject_message(input logic [2:0] st);
        report_t r;
        r = '0;
        r.status = st;
        parse_phase = PARSE_HUNT;
        expected_reports.push_back(r);
    endfunction

    function automatic void advance_parser(input logic [7:0] b);
        mcp_pkg::code_dec_t d;
        report_t            r;
        if (b == mcp_pkg::CH_START) begin
            parse_phase = PARSE_ID;
            name_index  = '0;
            code_chars  = '0;
            field_index = '0;
            return;
        end
        case (parse_phase)
            PARSE_ID: begin
                if (b == mcp_pkg::CH_END) begin
                    if (name_index != name_chars()) begin
                        reject_message(mcp_pkg::ST_NAME_MISMATCH);
                    end else begin
                        parse_phase = PARSE_FIELD_EMPTY;
                        code_chars  = '0;
                        field_index = '0;
                    end
                end else if (name_index >= name_chars() ||
                             b != cur_node_name[8*name_index[2:0] +: 8]) begin
                    reject_message(mcp_pkg::ST_NAME_MISMATCH);
                end else begin
                    name_index = name_index + 4'd1;
                end
            end
            PARSE_FIELD_EMPTY, PARSE_FIELD_ONE, PARSE_FIELD_TWO: begin
                if (b != mcp_pkg::CH_END) begin
                    if (parse_phase == PARSE_FIELD_EMPTY
                            && field_index == mcp_pkg::FLD_MOTOR
                            && b == mcp_pkg::CH_RENAME) begin
                        reject_message(mcp_pkg::ST_RENAME);
                    end else if (parse_phase == PARSE_FIELD_TWO) begin
                        reject_message(mcp_pkg::ST_FIELD_LONG);
                    end else begin
                        code_chars  = {code_chars[7:0], b};
                        parse_phase = parse_phase_t'(parse_phase + 3'd1);
                    end
                end else if (parse_phase != PARSE_FIELD_TWO) begin
                    reject_message(3'(mcp_pkg::ST_BAD_MOTOR + field_index));
                end else begin
                    d = decode_code(field_index, code_chars);
                    if (!d.ok) begin
                        reject_message(3'(mcp_pkg::ST_BAD_MOTOR + field_index));
                    end else if (field_index == mcp_pkg::FLD_RATE) begin
                        r = '0;
                        r.status      = mcp_pkg::ST_OK;
                        r.motor_mode  = kept_motor;
                        r.pwm_channel = kept_pwm;
                        r.direction   = kept_direction;
                        r.rate_code   = d.value;
                        parse_phase   = PARSE_HUNT;
                        expected_reports.push_back(r);
                    end else begin
                        case (field_index)
                            mcp_pkg::FLD_MOTOR: kept_motor     = d.value[1:0];
                            mcp_pkg::FLD_PWM:   kept_pwm       = d.value[1:0];
                            default:            kept_direction = d.value[1:0];
                        endcase
                        field_index = field_index + 2'd1;
                        code_chars  = '0;
                        parse_phase = PARSE_FIELD_EMPTY;
                    end
                end
            end
            default: parse_phase = PARSE_HUNT;
        endcase
    endfunction

    always @(posedge aclk) begin : result_check
        report_t got;
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result word: got %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch: expected st %0d mm %0d pwm %0d %s",
                             $time, want.status, want.motor_mode, want.pwm_channel,
                             $sformatf("dir %0d rate %0d pad %0d",
                                       want.direction, want.rate_code, want.pad));
                    $display("%0t: result mismatch: got st %0d mm %0d pwm %0d %s",
                             $time, got.status, got.motor_mode, got.pwm_channel,
                             $sformatf("dir %0d rate %0d pad %0d",
                                       got.direction, got.rate_code, got.pad));
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        advance_parser(b);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_name_regs(input logic [63:0] name, input logic [3:0] len);
        wait_results();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= mcp_pkg::CFG_NODE_NAME;
        cfg_wr_data <= name;
        @(posedge aclk);
        cfg_addr    <= mcp_pkg::CFG_NAME_LENGTH;
        cfg_wr_data <= 64'(len);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_node_name   = name;
        cur_name_length = len;
    endtask

    function automatic void add_header();
        frame_bytes.push_back(mcp_pkg::CH_START);
        for (int k = 0; k < name_chars(); k++)
            frame_bytes.push_back(cur_node_name[8*k +: 8]);
        frame_bytes.push_back(mcp_pkg::CH_END);
    endfunction

    function automatic void add_code(input logic [15:0] code);
        frame_bytes.push_back(code[15:8]);
        frame_bytes.push_back(code[7:0]);
        frame_bytes.push_back(mcp_pkg::CH_END);
    endfunction

    function automatic void add_command(input logic [15:0] mm, input logic [15:0] pp,
                                        input logic [15:0] dd, input logic [15:0] rr);
        add_header();
        add_code(mm);
        add_code(pp);
        add_code(dd);
        add_code(rr);
    endfunction

    function automatic logic [15:0] random_code(input logic [1:0] field);
        case (field)
            mcp_pkg::FLD_MOTOR:
                return {mcp_pkg::CH_ZERO, 8'(mcp_pkg::CH_ZERO + $urandom_range(3))};
            mcp_pkg::FLD_PWM:
                return {mcp_pkg::CH_ONE, 8'(mcp_pkg::CH_ONE + $urandom_range(3))};
            mcp_pkg::FLD_DIRECTION: begin
                if ($urandom_range(2) == 0)
                    return {mcp_pkg::CH_NINE, mcp_pkg::CH_NINE};
                return {mcp_pkg::CH_TWO, 8'(mcp_pkg::CH_ZERO + $urandom_range(1))};
            end
            default: begin
                if ($urandom_range(4) == 0)
                    return {mcp_pkg::CH_NINE, mcp_pkg::CH_NINE};
                return {mcp_pkg::CH_FOUR, 8'(mcp_pkg::CH_ONE + $urandom_range(3))};
            end
        endcase
    endfunction

    function automatic void add_random_command();
        add_command(random_code(mcp_pkg::FLD_MOTOR), random_code(mcp_pkg::FLD_PWM),
                    random_code(mcp_pkg::FLD_DIRECTION), random_code(mcp_pkg::FLD_RATE));
    endfunction

    task automatic load_random_name();
        logic [63:0] name;
        logic [7:0]  ch;
        for (int k = 0; k < 8; k++) begin
            ch = 8'($urandom_range(255));
            if (ch == mcp_pkg::CH_START || ch == mcp_pkg::CH_END)
                ch = mcp_pkg::CH_NINE;
            name[8*k +: 8] = ch;
        end
        write_name_regs(name, 4'($urandom_range(1, mcp_pkg::MAX_NAME_CHARS)));
    endtask

    task automatic send_random_frame();
        int hdr;
        int pos;
        hdr = name_chars() + 2;
        add_random_command();
        if ($urandom_range(99) >= 70) begin
            pos = $urandom_range(1, frame_bytes.size() - 1);
            case ($urandom_range(5))
                0: frame_bytes[pos] = 8'($urandom_range(255));
                1: frame_bytes.insert(pos, 8'($urandom_range(255)));
                2: frame_bytes.delete(pos);
                3: frame_bytes.insert(pos, mcp_pkg::CH_START);
                4: frame_bytes.insert(hdr, mcp_pkg::CH_RENAME);
                default: frame_bytes[hdr + 3*$urandom_range(3) + $urandom_range(1)] =
                             8'(mcp_pkg::CH_ZERO + $urandom_range(9));
            endcase
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) frame_bytes.push_front(8'($urandom_range(255)));
        if ($urandom_range(4) == 0)
            frame_bytes.push_back(8'($urandom_range(255)));
        send_frame();
    endtask

    task automatic test_good_commands();
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_ONE, mcp_pkg::CH_ONE},
                    {mcp_pkg::CH_TWO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_FOUR, mcp_pkg::CH_ONE});
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_THREE}, {mcp_pkg::CH_ONE, mcp_pkg::CH_FOUR},
                    {mcp_pkg::CH_TWO, mcp_pkg::CH_ONE}, {mcp_pkg::CH_FOUR, mcp_pkg::CH_FOUR});
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_ONE}, {mcp_pkg::CH_ONE, mcp_pkg::CH_TWO},
                    {mcp_pkg::CH_NINE, mcp_pkg::CH_NINE}, {mcp_pkg::CH_NINE, mcp_pkg::CH_NINE});
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_TWO}, {mcp_pkg::CH_ONE, mcp_pkg::CH_THREE},
                    {mcp_pkg::CH_NINE, mcp_pkg::CH_NINE}, {mcp_pkg::CH_FOUR, mcp_pkg::CH_THREE});
        send_frame();
    endtask

    task automatic test_name_checks();
        add_random_command();
        frame_bytes[2] = frame_bytes[2] ^ 8'h20;
        send_frame();
        add_random_command();
        frame_bytes.insert(name_chars() + 1, frame_bytes[1]);
        send_frame();
        add_random_command();
        frame_bytes.delete(name_chars());
        send_frame();
    endtask

    task automatic test_field_errors();
        add_header();
        frame_bytes.push_back(mcp_pkg::CH_RENAME);
        add_header();
        frame_bytes.push_back(mcp_pkg::CH_ZERO);
        frame_bytes.push_back(mcp_pkg::CH_RENAME);
        frame_bytes.push_back(mcp_pkg::CH_END);
        add_header();
        frame_bytes.push_back(mcp_pkg::CH_ZERO);
        frame_bytes.push_back(mcp_pkg::CH_ZERO);
        frame_bytes.push_back(mcp_pkg::CH_ZERO);
        add_header();
        add_code({mcp_pkg::CH_NINE, mcp_pkg::CH_NINE});
        send_frame();
        for (int f = 0; f < 4; f++) begin
            add_header();
            for (int k = 0; k < f; k++)
                add_code(random_code(2'(k)));
            frame_bytes.push_back(8'(random_code(2'(f)) >> 8));
            frame_bytes.push_back(mcp_pkg::CH_END);
            add_header();
            for (int k = 0; k < f; k++)
                add_code(random_code(2'(k)));
            frame_bytes.push_back(mcp_pkg::CH_END);
            send_frame();
        end
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_FOUR}, {mcp_pkg::CH_ONE, mcp_pkg::CH_ONE},
                    {mcp_pkg::CH_TWO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_FOUR, mcp_pkg::CH_ONE});
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_ONE, mcp_pkg::CH_ZERO},
                    {mcp_pkg::CH_TWO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_FOUR, mcp_pkg::CH_ONE});
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_ONE, mcp_pkg::CH_ONE},
                    {mcp_pkg::CH_TWO, mcp_pkg::CH_TWO}, {mcp_pkg::CH_FOUR, mcp_pkg::CH_ONE});
        add_command({mcp_pkg::CH_ZERO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_ONE, mcp_pkg::CH_ONE},
                    {mcp_pkg::CH_TWO, mcp_pkg::CH_ZERO}, {mcp_pkg::CH_FOUR, mcp_pkg::CH_ZERO});
        send_frame();
    endtask

    task automatic test_restart_and_noise();
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(mcp_pkg::CH_END);
        frame_bytes.push_back(mcp_pkg::CH_RENAME);
        add_random_command();
        add_header();
        frame_bytes.push_back(mcp_pkg::CH_ZERO);
        add_random_command();
        frame_bytes.push_back(mcp_pkg::CH_START);
        frame_bytes.push_back(cur_node_name[7:0]);
        add_random_command();
        frame_bytes.push_back(mcp_pkg::CH_ZERO);
        frame_bytes.push_back(mcp_pkg::CH_END);
        send_frame();
    endtask

    task automatic test_name_registers();
        write_name_regs('1, 4'd8);
        add_random_command();
        add_random_command();
        frame_bytes.delete(8);
        send_frame();
        write_name_regs('0, 4'd15);
        add_random_command();
        add_random_command();
        frame_bytes.insert(9, 8'h00);
        send_frame();
        write_name_regs(64'(mcp_pkg::CH_NINE), 4'd0);
        add_random_command();
        frame_bytes.push_back(mcp_pkg::CH_START);
        frame_bytes.push_back(mcp_pkg::CH_NINE);
        frame_bytes.push_back(mcp_pkg::CH_END);
        send_frame();
        write_name_regs(64'(mcp_pkg::CH_RENAME), 4'd1);
        add_random_command();
        send_frame();
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned nbytes);
        int unsigned stop_at;
        load_random_name();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) begin
            send_random_frame();
            if ($urandom_range(39) == 0)
                load_random_name();
            else if ($urandom_range(24) == 0)
                wait_results();
        end
    endtask

    initial begin
        send_idle_pct = 15;
        recv_idle_pct = 46;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_good_commands();
        test_name_checks();
        test_field_errors();
        test_restart_and_noise();
        test_name_registers();
        test_random_traffic(15, 46, 435);
        test_random_traffic(46, 15, 435);
        test_random_traffic(0, 0, 435);
        wait_results();
        if (error_count == 0)
            $display("** motor_command_parser: PASSED **");
        else
            $display("** motor_command_parser: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
design/mcp_pkg.sv
design/mcp_code_decode.sv
design/motor_command_parser.sv
test/testbench.sv
